// ===== hw/rtl/m4vt_pkg.sv =====
// ----------------------------------------------------------------------------
// m4vt_pkg - shared types and constants for the 4x4 matrix-vector transform
// Component widths, register layout, lane count and the per-lane result type.
// ----------------------------------------------------------------------------
package m4vt_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COMP_W      = 32;
  localparam int NUM_LANES   = 4;
  localparam int NUM_COLS    = 4;
  localparam int NUM_REGS    = 8;
  localparam int REG_W       = 2 * COMP_W;
  localparam int CFG_IDX_W   = $clog2(NUM_REGS);
  localparam int IN_DATA_W   = NUM_COLS * COMP_W;
  localparam int OUT_FIELD_W = NUM_LANES * COMP_W + 1;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int LANE_LAT    = 4;
  localparam int FIFO_DEPTH  = 8;

  typedef struct packed {
    logic [COMP_W-1:0] value;
    logic              sat;
  } lane_res_t;

  // Reset value of a matrix register: identity with the given fraction bits.
  // Register idx holds column idx>>1, rows 2*(idx&1) (low) and 2*(idx&1)+1 (high).
  function automatic logic [REG_W-1:0] ident_reg(input int idx, input int frac);
    int                col;
    int                row_lo;
    logic [COMP_W-1:0] one;
    logic [REG_W-1:0]  val;
    col    = idx >> 1;
    row_lo = (idx & 1) << 1;
    one    = COMP_W'(1) << frac;
    val    = '0;
    if (row_lo == col) begin
      val[COMP_W-1:0] = one;
    end
    if (row_lo + 1 == col) begin
      val[REG_W-1:COMP_W] = one;
    end
    return val;
  endfunction

endpackage

// ===== hw/rtl/m4vt_lane.sv =====
// ----------------------------------------------------------------------------
// m4vt_lane - one output row of the transform
// Four products, a two-level adder tree, round half up at the fixed point,
// then saturation to 32 bits. Free-running four-stage pipeline.
// ----------------------------------------------------------------------------
module m4vt_lane #(
  parameter int FRAC_BITS = m4vt_pkg::FRAC_BITS
) (
  input  logic                                            clk,
  input  logic [m4vt_pkg::NUM_COLS-1:0][m4vt_pkg::COMP_W-1:0] coef,
  input  logic [m4vt_pkg::NUM_COLS-1:0][m4vt_pkg::COMP_W-1:0] vec,
  output m4vt_pkg::lane_res_t                             res
);

  localparam int CW     = m4vt_pkg::COMP_W;
  localparam int PROD_W = 2 * CW;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 3;
  localparam int HI_LSB = FRAC_BITS + CW - 1;
  localparam int HI_W   = SUM_W - HI_LSB;
  localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  logic signed [PROD_W-1:0] prod [m4vt_pkg::NUM_COLS];
  logic signed [PAIR_W-1:0] pair0;
  logic signed [PAIR_W-1:0] pair1;
  logic signed [SUM_W-1:0]  sum;
  logic [HI_W-1:0]          sum_hi;
  logic                     in_range;

  always_ff @(posedge clk) begin
    for (int c = 0; c < m4vt_pkg::NUM_COLS; c++) begin
      prod[c] <= $signed(coef[c]) * $signed(vec[c]);
    end
  end

  always_ff @(posedge clk) begin
    pair0 <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
    pair1 <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
  end

  always_ff @(posedge clk) begin
    sum <= SUM_W'(pair0) + SUM_W'(pair1) + ROUND;
  end

  assign sum_hi   = sum[SUM_W-1:HI_LSB];
  assign in_range = (sum_hi == '0) || (sum_hi == '1);

  always_ff @(posedge clk) begin
    res.sat <= !in_range;
    if (in_range) begin
      res.value <= sum[FRAC_BITS +: CW];
    end else if (sum[SUM_W-1]) begin
      res.value <= SAT_MIN;
    end else begin
      res.value <= SAT_MAX;
    end
  end

endmodule

// ===== hw/rtl/m4vt_merge.sv =====
// ----------------------------------------------------------------------------
// m4vt_merge - lane merge and output queue
// Packs the four lane results with the combined overflow flag into an output
// queue and tracks items in flight so the input side never outruns the queue.
// ----------------------------------------------------------------------------
module m4vt_merge (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_accept,
  input  logic                                              push,
  input  m4vt_pkg::lane_res_t [m4vt_pkg::NUM_LANES-1:0]     lane_res,
  output logic                                              in_ready,
  output logic                                              m_tvalid,
  input  logic                                              m_tready,
  output logic [m4vt_pkg::OUT_DATA_W-1:0]                   m_tdata
);

  localparam int DEPTH = m4vt_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = m4vt_pkg::COMP_W;
  localparam int PAD_W = m4vt_pkg::OUT_DATA_W - m4vt_pkg::OUT_FIELD_W;

  logic [m4vt_pkg::OUT_DATA_W-1:0] fifo [DEPTH];
  logic [PTR_W-1:0]                wr_ptr;
  logic [PTR_W-1:0]                rd_ptr;
  logic [CNT_W-1:0]                fifo_cnt;
  logic [CNT_W-1:0]                occ;
  logic                            deliver;
  logic                            any_sat;
  logic [m4vt_pkg::NUM_LANES*CW-1:0] comps;
  logic [m4vt_pkg::OUT_DATA_W-1:0] packed_item;

  always_comb begin
    any_sat = 1'b0;
    for (int l = 0; l < m4vt_pkg::NUM_LANES; l++) begin
      comps[l*CW +: CW] = lane_res[l].value;
      any_sat           = any_sat | lane_res[l].sat;
    end
  end

  assign packed_item = {{PAD_W{1'b0}}, any_sat, comps};
  assign deliver     = m_tvalid && m_tready;
  assign m_tvalid    = (fifo_cnt != '0);
  assign m_tdata     = fifo[rd_ptr];
  assign in_ready    = (occ < CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= packed_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      occ      <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (deliver) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fifo_cnt <= fifo_cnt + CNT_W'(push) - CNT_W'(deliver);
      occ      <= occ + CNT_W'(in_accept) - CNT_W'(deliver);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_cnt < CNT_W'(DEPTH)))
    else $error("output queue written while full");

  a_queue_within_occ: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= occ)
    else $error("queued items exceed items in flight");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(DEPTH))
    else $error("items in flight exceed queue depth");

  a_occ_track: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !deliver) |=> (occ == $past(occ) + CNT_W'(1)))
    else $error("in-flight count missed an accepted item");
`endif

endmodule

// ===== hw/rtl/matrix4_vector_transform.sv =====
// ----------------------------------------------------------------------------
// matrix4_vector_transform - 4x4 fixed-point matrix times homogeneous vector
// Column-major matrix in eight config registers, four row lanes, merged output.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one vector item per cycle while s_tready is high (x, y, z, w,
//   signed, FRAC_BITS fraction bits). m_* returns one result item per input:
//   four rounded, saturated row sums and an overflow flag set if any row saturated.
//   cfg_we/cfg_index/cfg_data write matrix register cfg_index (two coefficients
//   each, lower row in bits 31..0); write only while no item is in flight.
// Path: the input register at the accepting edge, four lane stages, then the
//   output queue write, from which the result is presented.
// Throughput: one item per cycle if s_tready; each lane has its own four multipliers.
// Stall: results collect in an 8-entry output queue; s_tready drops once
//   8 items are accepted but not yet delivered, and no item is ever lost.
// Reset: the matrix returns to identity and the queue empties; s_tready is
//   high in the cycle after reset is released.
// ----------------------------------------------------------------------------
module matrix4_vector_transform #(
  parameter int FRAC_BITS = m4vt_pkg::FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [m4vt_pkg::IN_DATA_W-1:0]     s_tdata,   // vec_x, vec_y, vec_z, vec_w
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [m4vt_pkg::OUT_DATA_W-1:0]    m_tdata,   // out_x, out_y, out_z, out_w,
                                                        // overflow, zero pad
  input  logic                               cfg_we,
  input  logic [m4vt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [m4vt_pkg::REG_W-1:0]         cfg_data
);

  localparam int CW    = m4vt_pkg::COMP_W;
  localparam int NCOL  = m4vt_pkg::NUM_COLS;
  localparam int NLANE = m4vt_pkg::NUM_LANES;
  localparam int LAT   = m4vt_pkg::LANE_LAT;

  logic [m4vt_pkg::REG_W-1:0]  mat_regs [m4vt_pkg::NUM_REGS];
  logic [NCOL-1:0][CW-1:0]     vec;
  logic                        vec_valid;
  logic [LAT-1:0]              valid_pipe;
  logic                        in_accept;
  m4vt_pkg::lane_res_t [NLANE-1:0] lane_res;

  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < m4vt_pkg::NUM_REGS; i++) begin
        mat_regs[i] <= m4vt_pkg::ident_reg(i, FRAC_BITS);
      end
    end else if (cfg_we) begin
      mat_regs[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      vec <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vec_valid  <= 1'b0;
      valid_pipe <= '0;
    end else begin
      vec_valid  <= in_accept;
      valid_pipe <= {valid_pipe[LAT-2:0], vec_valid};
    end
  end

  for (genvar r = 0; r < NLANE; r++) begin : g_lane
    logic [NCOL-1:0][CW-1:0] coef;
    for (genvar c = 0; c < NCOL; c++) begin : g_coef
      assign coef[c] = mat_regs[2 * c + (r >> 1)][(r & 1) * CW +: CW];
    end

    m4vt_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .coef (coef),
      .vec  (vec),
      .res  (lane_res[r])
    );
  end

  m4vt_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .push      (valid_pipe[LAT-1]),
    .lane_res  (lane_res),
    .in_ready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
